@@ design/khce_pkg.sv @@
// ----------------------------------------------------------------------------
// khce_pkg: shared types and constants
// request codes, response status codes and the fixed-point constants of the
// hermite curve evaluator
// ----------------------------------------------------------------------------
package khce_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_EVAL   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_VALUE = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_OK    = 2'd3
   } status_type;

   // fraction bits of the curve parameter t
   localparam int T_BITS   = 30;
   // operand width of the shared multiplier
   localparam int MUL_W    = 35;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int KEY_W    = 32;
   localparam int REC_W    = 3 * KEY_W;

endpackage

@@ design/khce_ram.sv @@
// ----------------------------------------------------------------------------
// khce_ram: simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module khce_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/keyframe_hermite_curve_eval.sv @@
// ----------------------------------------------------------------------------
// keyframe_hermite_curve_eval: cubic hermite keyframe curve evaluator
// keyframe table in one ram, sequenced key walk, iterative divider and one
// shared multiplier for the hermite basis and blend
// ----------------------------------------------------------------------------
// clear, append and evaluate on an empty table: the response goes out from the
//   finish state once the response register is free; one request at a time
// evaluate: a frame at or before the first key or at or after the last key
//   returns that key's value; an interior frame walks the keys through the
//   single ram read port, then runs the 30-step restoring divider for t
// reset clears the key count and the handshake state only; ram is not cleared
// ----------------------------------------------------------------------------
module keyframe_hermite_curve_eval #(
   parameter int MAX_KEYS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: frame_pos [31:0], key_value [63:32], key_slope [95:64]
   input  logic [95:0]  req_tdata,
   // tuser: opcode [1:0]
   input  logic [1:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: result_value [31:0]
   output logic [31:0]  rsp_tdata,
   // tuser: status [1:0]
   output logic [1:0]   rsp_tuser
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = AW + 1;
   localparam int KW = khce_pkg::KEY_W;
   localparam int MW = khce_pkg::MUL_W;
   localparam int PW = khce_pkg::PROD_W;
   localparam int TB = khce_pkg::T_BITS;

   localparam logic signed [MW-1:0] T_ONE  = MW'(1) <<< TB;
   localparam logic signed [PW-1:0] SAT_HI = PW'(64'sd2147483647);
   localparam logic signed [PW-1:0] SAT_LO = PW'(-64'sd2147483648);

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_LAST, S_WALK, S_DIV, S_T2, S_T3, S_H,
      S_MA, S_MB, S_MC, S_MD, S_ME, S_SAT, S_FINISH
   } state_type;

   state_type state_ff;

   // control
   logic [CW-1:0]   count_ff;
   logic [AW-1:0]   idx_ff;
   logic [4:0]      div_cnt_ff;
   logic            rsp_valid_ff;

   // payload
   logic signed [KW-1:0] frame_ff;
   logic signed [KW-1:0] f0_ff, v0_ff, s0_ff, v1_ff, s1_ff;
   logic [KW-1:0]        range_ff;
   logic [KW-1:0]        rem_ff;
   logic [TB:0]          q_ff;
   logic [TB:0]          t2_ff, t3_ff;
   logic signed [MW-1:0] h00_ff, h01_ff, h10_ff, h11_ff;
   logic signed [MW-1:0] tan_ff, val_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [KW-1:0] result_ff, rsp_data_ff;
   khce_pkg::status_type status_ff, rsp_status_ff;

   // request decode
   logic                  req_accept;
   khce_pkg::opcode_type  req_op;
   logic signed [KW-1:0]  req_frame;
   logic                  table_full;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = khce_pkg::opcode_type'(req_tuser);
   assign req_frame  = $signed(req_tdata[KW-1:0]);
   assign table_full = (count_ff >= CW'(MAX_KEYS));

   // keyframe ram: record is {slope, value, frame}
   logic                          ram_we;
   logic [AW-1:0]                 rd_addr;
   logic [khce_pkg::REC_W-1:0]    rd_rec;
   logic signed [KW-1:0]          rd_f, rd_v, rd_s;
   logic [CW-1:0]                 cnt_m1;

   assign ram_we = req_accept && (req_op == khce_pkg::OP_APPEND) && !table_full;
   assign cnt_m1 = count_ff - CW'(1);
   assign rd_f   = $signed(rd_rec[KW-1:0]);
   assign rd_v   = $signed(rd_rec[2*KW-1:KW]);
   assign rd_s   = $signed(rd_rec[3*KW-1:2*KW]);

   // read address is set in the state before the one that consumes the registered read data
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = '0;
         S_FIRST: rd_addr = cnt_m1[AW-1:0];
         S_LAST:  rd_addr = AW'(1);
         S_WALK:  rd_addr = idx_ff + AW'(1);
         default: rd_addr = '0;
      endcase
   end

   khce_ram #(
      .WIDTH (khce_pkg::REC_W),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_rec)
   );

   // segment set-up when the walk finds its end key
   logic [KW:0]   range_full, num_full;
   logic [KW-1:0] seg_range, seg_num;
   logic          first_q;

   assign range_full = {rd_f[KW-1], rd_f} - {f0_ff[KW-1], f0_ff};
   assign num_full   = {frame_ff[KW-1], frame_ff} - {f0_ff[KW-1], f0_ff};
   assign seg_range  = range_full[KW-1:0];
   assign seg_num    = num_full[KW-1:0];
   assign first_q    = (seg_num >= seg_range);

   // restoring divider step
   logic [KW:0] rem_sh;
   logic        div_bit;

   assign rem_sh  = {rem_ff, 1'b0};
   assign div_bit = (rem_sh >= {1'b0, range_ff});

   // shared multiplier
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod, acc_sum, sat_sum;

   always_comb begin
      case (state_ff)
         S_T2:    begin mul_a = $signed(MW'(q_ff));  mul_b = $signed(MW'(q_ff)); end
         S_T3:    begin mul_a = $signed(MW'(t2_ff)); mul_b = $signed(MW'(q_ff)); end
         S_MA:    begin mul_a = h10_ff;              mul_b = MW'(s0_ff);        end
         S_MB:    begin mul_a = h11_ff;              mul_b = MW'(s1_ff);        end
         S_MC:    begin mul_a = h00_ff;              mul_b = MW'(v0_ff);        end
         S_MD:    begin mul_a = h01_ff;              mul_b = MW'(v1_ff);        end
         S_ME:    begin mul_a = tan_ff;              mul_b = $signed(MW'(range_ff)); end
         default: begin mul_a = '0;                  mul_b = '0;                end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign acc_sum = acc_ff + prod;
   assign sat_sum = (acc_ff >>> FRAC_BITS) + PW'(val_ff);

   // hermite basis from t, t2, t3
   logic signed [MW-1:0] t_s, t2_s, t3_s;

   assign t_s  = $signed(MW'(q_ff));
   assign t2_s = $signed(MW'(t2_ff));
   assign t3_s = $signed(MW'(t3_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the finish state handles its own response hand-over
         if (rsp_valid_ff && rsp_tready && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  frame_ff  <= req_frame;
                  result_ff <= '0;
                  status_ff <= khce_pkg::ST_OK;
                  state_ff  <= S_FINISH;
                  case (req_op)
                     khce_pkg::OP_CLEAR: begin
                        count_ff <= '0;
                     end
                     khce_pkg::OP_APPEND: begin
                        if (table_full) begin
                           status_ff <= khce_pkg::ST_FULL;
                        end else begin
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     khce_pkg::OP_EVAL: begin
                        if (count_ff == '0) begin
                           status_ff <= khce_pkg::ST_EMPTY;
                        end else begin
                           status_ff <= khce_pkg::ST_VALUE;
                           state_ff  <= S_FIRST;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_FIRST: begin
               // first key on the read port
               f0_ff <= rd_f;
               v0_ff <= rd_v;
               s0_ff <= rd_s;
               if (count_ff == CW'(1) || frame_ff <= rd_f) begin
                  result_ff <= rd_v;
                  state_ff  <= S_FINISH;
               end else begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               // last key: hold its value past the end of the span
               if (frame_ff >= rd_f) begin
                  result_ff <= rd_v;
                  state_ff  <= S_FINISH;
               end else begin
                  idx_ff   <= AW'(1);
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (rd_f >= frame_ff) begin
                  // segment end found, start the division for t
                  v1_ff      <= rd_v;
                  s1_ff      <= rd_s;
                  range_ff   <= seg_range;
                  rem_ff     <= first_q ? (seg_num - seg_range) : seg_num;
                  q_ff       <= (TB+1)'(first_q);
                  div_cnt_ff <= '0;
                  state_ff   <= S_DIV;
               end else begin
                  f0_ff  <= rd_f;
                  v0_ff  <= rd_v;
                  s0_ff  <= rd_s;
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            S_DIV: begin
               rem_ff     <= div_bit ? KW'(rem_sh - {1'b0, range_ff}) : rem_sh[KW-1:0];
               q_ff       <= {q_ff[TB-1:0], div_bit};
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'(TB - 1)) begin
                  state_ff <= S_T2;
               end
            end
            S_T2: begin
               t2_ff    <= prod[2*TB:TB];
               state_ff <= S_T3;
            end
            S_T3: begin
               t3_ff    <= prod[2*TB:TB];
               state_ff <= S_H;
            end
            S_H: begin
               h00_ff   <= (t3_s <<< 1) - (t2_s + (t2_s <<< 1)) + T_ONE;
               h01_ff   <= (t2_s + (t2_s <<< 1)) - (t3_s <<< 1);
               h10_ff   <= t3_s - (t2_s <<< 1) + t_s;
               h11_ff   <= t3_s - t2_s;
               state_ff <= S_MA;
            end
            S_MA: begin
               acc_ff   <= prod;
               state_ff <= S_MB;
            end
            S_MB: begin
               tan_ff   <= acc_sum[TB+MW-1:TB];
               state_ff <= S_MC;
            end
            S_MC: begin
               acc_ff   <= prod;
               state_ff <= S_MD;
            end
            S_MD: begin
               val_ff   <= acc_sum[TB+MW-1:TB];
               state_ff <= S_ME;
            end
            S_ME: begin
               acc_ff   <= prod;
               state_ff <= S_SAT;
            end
            S_SAT: begin
               if (sat_sum > SAT_HI) begin
                  result_ff <= SAT_HI[KW-1:0];
               end else if (sat_sum < SAT_LO) begin
                  result_ff <= SAT_LO[KW-1:0];
               end else begin
                  result_ff <= sat_sum[KW-1:0];
               end
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               // wait for the response register to be free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= result_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEYS))
      else $error("key count beyond table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == khce_pkg::OP_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the table");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (range_ff != '0 && rem_ff < range_ff))
      else $error("divider remainder out of range");

   a_t_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T2) |-> (q_ff <= (TB+1)'(T_ONE)))
      else $error("curve parameter above one");
`endif

endmodule
